// File: rtl/fdu_pkg.sv
`default_nettype none
package fdu_pkg;

  localparam int CODE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int TABLE_W     = 64;
  localparam int NUM_TABLE   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int LEFT_W      = 4;
  localparam int LEFT_CNT_W  = 3;
  localparam int ACC_W       = LEFT_W + BYTE_W;
  localparam int AVAIL_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0] END_CODE = 5'h1F;

  // One queue entry: the codes a single input byte produced, in order
  typedef struct packed {
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
    logic              two;
  } fdu_entry_t;

endpackage
`default_nettype wire

// File: rtl/fdu_front.sv
`default_nettype none
module fdu_front
  import fdu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output fdu_entry_t             q_entry
);

  logic [LEFT_W-1:0]     left_bits_r, left_bits_nxt;
  logic [LEFT_CNT_W-1:0] left_cnt_r, left_cnt_nxt;
  logic                  done_r, done_nxt;

  logic [ACC_W-1:0]      acc;
  logic [AVAIL_W-1:0]    avail;
  logic [LEFT_CNT_W-1:0] rem1;
  logic [LEFT_CNT_W-1:0] rem;
  logic                  has2;
  logic [CODE_W-1:0]     code0;
  logic [CODE_W-1:0]     code1;
  logic [ACC_W-1:0]      rem_mask;
  logic                  accept;

  // Split held-over bits plus the new byte into one or two codes
  always_comb begin
    acc      = {left_bits_r, in_byte};
    avail    = AVAIL_W'(left_cnt_r) + AVAIL_W'(BYTE_W);
    rem1     = LEFT_CNT_W'(avail - AVAIL_W'(CODE_W));
    has2     = (rem1 >= LEFT_CNT_W'(CODE_W));
    code0    = CODE_W'(acc >> rem1);
    code1    = CODE_W'(acc >> (rem1 - LEFT_CNT_W'(CODE_W)));
    rem      = has2 ? (rem1 - LEFT_CNT_W'(CODE_W)) : rem1;
    rem_mask = (ACC_W'(1) << rem) - ACC_W'(1);
  end

  // Classify the byte and update the carry state
  always_comb begin
    accept        = in_push && !q_full;
    q_push        = 1'b0;
    q_entry.code0 = code0;
    q_entry.code1 = code1;
    q_entry.two   = has2;
    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    done_nxt      = done_r;
    if (accept && !done_r) begin
      if (code0 == END_CODE) begin
        done_nxt      = 1'b1;
        left_bits_nxt = '0;
        left_cnt_nxt  = '0;
      end else if (has2 && (code1 == END_CODE)) begin
        q_push        = 1'b1;
        q_entry.two   = 1'b0;
        done_nxt      = 1'b1;
        left_bits_nxt = '0;
        left_cnt_nxt  = '0;
      end else begin
        q_push        = 1'b1;
        left_cnt_nxt  = rem;
        left_bits_nxt = LEFT_W'(acc & rem_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= '0;
      left_cnt_r  <= '0;
      done_r      <= 1'b0;
    end else begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fdu_queue.sv
`default_nettype none
module fdu_queue
  import fdu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire fdu_entry_t wdata,
  output logic            full,
  input  wire logic       pop,
  output fdu_entry_t      rdata,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fdu_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fdu_back.sv
`default_nettype none
module fdu_back
  import fdu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TABLE_W-1:0]   cfg_data,
  input  wire fdu_entry_t           q_head,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      out_last_of_run,
  output logic                      out_empty,
  input  wire logic                 out_pop
);

  logic [TABLE_W-1:0] table_r [NUM_TABLE];
  logic [NUM_TABLE*TABLE_W-1:0] dict_flat;

  logic              valid_r, valid_nxt;
  logic              idx_r, idx_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  logic              take;
  logic              load;
  logic [CODE_W-1:0] cur_code;
  logic              cur_last;
  logic [CHAR_W-1:0] cur_char;

  // Dictionary registers; an index past the table list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TABLE; i++) begin
        table_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_TABLE))) begin
      table_r[cfg_index[$clog2(NUM_TABLE)-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TABLE; i++) begin
      dict_flat[i*TABLE_W +: TABLE_W] = table_r[i];
    end
  end

  // Pick the next code from the queue head and look it up
  always_comb begin
    take      = out_pop && valid_r;
    load      = !q_empty && (!valid_r || take);
    cur_code  = idx_r ? q_head.code1 : q_head.code0;
    cur_last  = idx_r || !q_head.two;
    cur_char  = dict_flat[{cur_code, 3'b000} +: CHAR_W];
    q_pop     = load && cur_last;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = !cur_last;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_char;
      last_r <= cur_last;
    end
  end

  assign out_char        = char_r;
  assign out_last_of_run = last_r;
  assign out_empty       = !valid_r;

endmodule
`default_nettype wire

// File: rtl/five_bit_code_dictionary_unpacker_core.sv
`default_nettype none
// Channel   Ports                                   Request moves
// input     in_push, in_full, in_byte               one packed byte
// result    out_pop, out_empty, out_char,
//           out_last_of_run                         one decoded character
// config    cfg_we, cfg_index, cfg_data             one 64-bit table word
//
// A byte is split into codes in the cycle it is taken; its codes wait in a
// small queue and the result register emits one character per cycle while
// out_pop keeps taking them. in_full rises only when the queue is full;
// rst_n clears carry state, the end flag, the queue and the dictionary
// words. After the end code every byte that is taken is dropped.
module five_bit_code_dictionary_unpacker_core
  import fdu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [BYTE_W-1:0]    in_byte,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      out_last_of_run,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TABLE_W-1:0]   cfg_data
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  fdu_entry_t q_wdata;
  fdu_entry_t q_head;

  assign in_full = q_full;

  fdu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_byte (in_byte),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wdata)
  );

  fdu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  fdu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_empty       (out_empty),
    .out_pop         (out_pop)
  );

endmodule
`default_nettype wire
